// ===== sv/mch_pkg.sv =====
// Package for the station address class table: sizes, command and status codes,
// and the request and response structs. No dependencies.
package mch_pkg;

  localparam int unsigned ENTRIES    = 1024;
  localparam int unsigned BUCKETS    = 256;
  localparam int unsigned CLASS_BITS = 32;
  localparam int unsigned ID_W       = $clog2(ENTRIES);
  localparam int unsigned BKT_W      = $clog2(BUCKETS);
  localparam int unsigned KEY_W      = 48;

  localparam logic [1:0] CMD_INSERT   = 2'd0;
  localparam logic [1:0] CMD_REMOVE   = 2'd1;
  localparam logic [1:0] CMD_LOOKUP   = 2'd2;
  localparam logic [1:0] CMD_RESERVED = 2'd3;

  localparam logic [2:0] STATUS_INSERTED = 3'd0;
  localparam logic [2:0] STATUS_UPDATED  = 3'd1;
  localparam logic [2:0] STATUS_FULL     = 3'd2;
  localparam logic [2:0] STATUS_REMOVED  = 3'd3;
  localparam logic [2:0] STATUS_ABSENT   = 3'd4;
  localparam logic [2:0] STATUS_FOUND    = 3'd5;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_REMOVE,
    OP_LOOKUP
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEAD,
    ST_HEADRD,
    ST_WALK,
    ST_ACT,
    ST_ALLOC,
    ST_LINK,
    ST_UNLINK
  } state_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [47:0] mac_address;
    logic [31:0] class_value;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        found;
    logic [31:0] class_out;
  } rsp_t;

  typedef struct packed {
    op_e                   op;
    logic [KEY_W-1:0]      key;
    logic [CLASS_BITS-1:0] cls;
    logic [BKT_W-1:0]      bucket;
  } item_t;

endpackage

// ===== sv/mch_front.sv =====
// Front end: takes requests, decodes the command and the bucket, and holds
// them in a two-deep queue for the back end. Depends on mch_pkg.
module mch_front import mch_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start,
  output logic  busy,
  input  req_t  req_i,
  input  logic  pop_i,
  output logic  avail_o,
  output item_t item_o
);

  item_t       slot_q [2];
  logic        wr_q, rd_q;
  logic [1:0]  cnt_q;
  logic        push;
  logic        pop;
  item_t       item_d;

  assign busy    = (cnt_q == 2'd2);
  assign push    = start && !busy;
  assign avail_o = (cnt_q != 2'd0);
  assign pop     = pop_i && avail_o;
  assign item_o  = slot_q[rd_q];

  always_comb begin
    case (req_i.cmd)
      CMD_INSERT: item_d.op = OP_INSERT;
      CMD_REMOVE: item_d.op = OP_REMOVE;
      default:    item_d.op = OP_LOOKUP;
    endcase
    item_d.key    = req_i.mac_address;
    item_d.cls    = req_i.class_value[CLASS_BITS-1:0];
    item_d.bucket = req_i.mac_address[BKT_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= item_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== sv/mch_back.sv =====
// Back end: bucket heads, entry pool, chain links and free list, with the
// sequencer that walks a chain and updates the links. Depends on mch_pkg.
module mch_back import mch_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  avail_i,
  input  item_t item_i,
  output logic  pop_o,
  output logic  done_o,
  output rsp_t  rsp_o
);

  localparam logic [ID_W-1:0] NULL_ID = '0;

  // Memories
  logic [KEY_W-1:0]      key_mem  [ENTRIES];
  logic [CLASS_BITS-1:0] cls_mem  [ENTRIES];
  logic [ID_W-1:0]       cn_mem   [ENTRIES];
  logic [ID_W-1:0]       cp_mem   [ENTRIES];
  logic [ID_W-1:0]       fn_mem   [ENTRIES];
  logic [ID_W-1:0]       bh_mem   [BUCKETS];

  logic [KEY_W-1:0]      key_rd;
  logic [CLASS_BITS-1:0] cls_rd;
  logic [ID_W-1:0]       cn_rd, cp_rd, fn_rd, bh_rd;

  logic [ID_W-1:0]       rd_addr;
  logic                  key_we, cls_we, cn_we, cp_we, fn_we, bh_we;
  logic [ID_W-1:0]       key_wa, cls_wa, cn_wa, cp_wa, fn_wa;
  logic [BKT_W-1:0]      bh_wa;
  logic [CLASS_BITS-1:0] cls_wd;
  logic [ID_W-1:0]       cn_wd, cp_wd, fn_wd, bh_wd;

  state_e                st_q, st_d;
  item_t                 it_q, it_d;
  logic [ID_W-1:0]       h_q, h_d, cur_q, cur_d, id_q, id_d;
  logic [ID_W-1:0]       prev_q, prev_d, next_q, next_d;
  logic [CLASS_BITS-1:0] hitcls_q, hitcls_d;
  logic [ID_W:0]         steps_q, steps_d;
  logic [ID_W-1:0]       fh_q, fh_d;
  logic [ID_W:0]         hw_q, hw_d;
  logic [BUCKETS-1:0]    bv_q, bv_d;
  logic                  done_q, done_d;
  rsp_t                  rsp_q, rsp_d;

  logic [ID_W-1:0]       head_id;
  logic                  hit;
  logic [ID_W-1:0]       fn_val;

  assign head_id = bv_q[it_q.bucket] ? bh_rd : NULL_ID;
  assign hit     = (key_rd == it_q.key);
  // Entries at or above the high-water mark were never allocated and still
  // link to their successor on the free list.
  assign fn_val  = ({1'b0, fh_q} >= hw_q) ? fh_q + 1'b1 : fn_rd;

  always_ff @(posedge clk_i) begin
    if (key_we) key_mem[key_wa] <= it_q.key;
    if (cls_we) cls_mem[cls_wa] <= cls_wd;
    if (cn_we)  cn_mem[cn_wa]   <= cn_wd;
    if (cp_we)  cp_mem[cp_wa]   <= cp_wd;
    if (fn_we)  fn_mem[fn_wa]   <= fn_wd;
    if (bh_we)  bh_mem[bh_wa]   <= bh_wd;
    key_rd <= key_mem[rd_addr];
    cls_rd <= cls_mem[rd_addr];
    cn_rd  <= cn_mem[rd_addr];
    cp_rd  <= cp_mem[rd_addr];
    fn_rd  <= fn_mem[fh_d];
    bh_rd  <= bh_mem[it_d.bucket];
  end

  // Next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE:   if (avail_i) st_d = ST_HEAD;
      ST_HEAD:   st_d = ST_HEADRD;
      ST_HEADRD: st_d = (head_id != NULL_ID) ? ST_WALK : ST_ACT;
      ST_WALK: begin
        if (hit || cn_rd == NULL_ID || steps_q >= (ID_W+1)'(ENTRIES)) st_d = ST_ACT;
      end
      ST_ACT: begin
        if (it_q.op == OP_INSERT && id_q == NULL_ID && fh_q != NULL_ID) begin
          st_d = ST_ALLOC;
        end else if (it_q.op == OP_REMOVE && id_q != NULL_ID) begin
          st_d = ST_UNLINK;
        end else begin
          st_d = ST_IDLE;
        end
      end
      ST_ALLOC:  st_d = ST_LINK;
      ST_LINK:   st_d = ST_IDLE;
      ST_UNLINK: st_d = ST_IDLE;
      default:   st_d = ST_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    it_d = it_q; h_d = h_q; cur_d = cur_q; id_d = id_q;
    prev_d = prev_q; next_d = next_q; hitcls_d = hitcls_q; steps_d = steps_q;
    fh_d = fh_q; hw_d = hw_q; bv_d = bv_q;
    done_d = 1'b0; rsp_d = rsp_q;
    pop_o = 1'b0;
    rd_addr = cur_q;
    key_we = 1'b0; cls_we = 1'b0; cn_we = 1'b0; cp_we = 1'b0; fn_we = 1'b0;
    bh_we = 1'b0;
    key_wa = fh_q; cls_wa = id_q; cn_wa = id_q; cp_wa = id_q; fn_wa = id_q;
    bh_wa = it_q.bucket;
    cls_wd = it_q.cls; cn_wd = NULL_ID; cp_wd = NULL_ID; fn_wd = NULL_ID;
    bh_wd = NULL_ID;
    case (st_q)
      ST_IDLE: begin
        if (avail_i) begin
          pop_o = 1'b1;
          it_d  = item_i;
        end
      end
      ST_HEADRD: begin
        h_d = head_id; cur_d = head_id; rd_addr = head_id;
        id_d = NULL_ID; steps_d = (ID_W+1)'(1);
      end
      ST_WALK: begin
        if (hit) begin
          id_d = cur_q; prev_d = cp_rd; next_d = cn_rd; hitcls_d = cls_rd;
        end else begin
          cur_d = cn_rd; rd_addr = cn_rd; steps_d = steps_q + 1'b1;
        end
      end
      ST_ACT: begin
        rsp_d.found     = (id_q != NULL_ID);
        rsp_d.class_out = '0;
        case (it_q.op)
          OP_INSERT: begin
            if (id_q != NULL_ID) begin
              cls_we = 1'b1; cls_wa = id_q;
              rsp_d.status = STATUS_UPDATED; done_d = 1'b1;
            end else if (fh_q == NULL_ID) begin
              rsp_d.status = STATUS_FULL; done_d = 1'b1;
            end else begin
              rsp_d.status = STATUS_INSERTED;
            end
          end
          OP_REMOVE: begin
            if (id_q != NULL_ID) begin
              rsp_d.status = STATUS_REMOVED;
              if (prev_q != NULL_ID) begin
                cn_we = 1'b1; cn_wa = prev_q; cn_wd = next_q;
              end else begin
                bh_we = 1'b1; bh_wd = next_q; bv_d[it_q.bucket] = 1'b1;
              end
              if (next_q != NULL_ID) begin
                cp_we = 1'b1; cp_wa = next_q; cp_wd = prev_q;
              end
            end else begin
              rsp_d.status = STATUS_ABSENT; done_d = 1'b1;
            end
          end
          default: begin
            if (id_q != NULL_ID) begin
              rsp_d.status = STATUS_FOUND; rsp_d.class_out = hitcls_q;
            end else begin
              rsp_d.status = STATUS_ABSENT;
            end
            done_d = 1'b1;
          end
        endcase
      end
      ST_ALLOC: begin
        key_we = 1'b1; key_wa = fh_q;
        cls_we = 1'b1; cls_wa = fh_q; cls_wd = it_q.cls;
        cn_we = 1'b1; cn_wa = fh_q; cn_wd = h_q;
        cp_we = 1'b1; cp_wa = fh_q; cp_wd = NULL_ID;
        fn_we = 1'b1; fn_wa = fh_q; fn_wd = NULL_ID;
        bh_we = 1'b1; bh_wd = fh_q; bv_d[it_q.bucket] = 1'b1;
        if ({1'b0, fh_q} >= hw_q) hw_d = {1'b0, fh_q} + 1'b1;
        id_d = fh_q;
        fh_d = fn_val;
      end
      ST_LINK: begin
        if (h_q != NULL_ID) begin
          cp_we = 1'b1; cp_wa = h_q; cp_wd = id_q;
        end
        done_d = 1'b1;
      end
      ST_UNLINK: begin
        cp_we = 1'b1; cp_wa = id_q; cp_wd = NULL_ID;
        cn_we = 1'b1; cn_wa = id_q; cn_wd = NULL_ID;
        fn_we = 1'b1; fn_wa = id_q; fn_wd = fh_q;
        fh_d = id_q;
        done_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    it_q <= it_d; h_q <= h_d; cur_q <= cur_d; id_q <= id_d;
    prev_q <= prev_d; next_q <= next_d; hitcls_q <= hitcls_d;
    steps_q <= steps_d; rsp_q <= rsp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      fh_q   <= (ID_W)'(1);
      hw_q   <= (ID_W+1)'(1);
      bv_q   <= '0;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      fh_q   <= fh_d;
      hw_q   <= hw_d;
      bv_q   <= bv_d;
      done_q <= done_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

`ifndef SYNTHESIS
  a_found_matches_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (rsp_o.found == (rsp_o.status == STATUS_UPDATED ||
      rsp_o.status == STATUS_REMOVED || rsp_o.status == STATUS_FOUND)))
    else $error("found flag disagrees with status");
  a_full_only_without_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status == STATUS_FULL) |-> (fh_q == NULL_ID))
    else $error("table full reported with a free entry");
  a_hw_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hw_q <= (ID_W+1)'(ENTRIES))
    else $error("high-water mark beyond pool");
  a_done_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(st_q) == ST_IDLE || st_q == ST_IDLE)
    else $error("result while an item is still in work");
`endif

endmodule

// ===== sv/mac_class_hash_table.sv =====
// Top level of the station address class table: front-end request queue and
// back-end table sequencer. Depends on mch_pkg, mch_front and mch_back.
//
// A transaction is taken at a rising edge where start is high and busy is low;
// up to two transactions queue in front of the table sequencer. Each produces
// exactly one response, shown for one cycle with done_o high; the receiver
// cannot stall it. A transaction reads its bucket head, walks the chain one
// entry at a time, and acts on the result; a new insert then allocates and
// links an entry, and the removal of a present key unlinks it.
// No clearing pass is needed after reset: bucket heads carry valid bits and
// untouched pool entries are tracked by a high-water mark.
module mac_class_hash_table import mch_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic done_o,
  output rsp_t rsp_o
);

  logic  avail, pop;
  item_t item;

  mch_front u_front (
    .clk_i, .rst_ni, .start, .busy, .req_i,
    .pop_i(pop), .avail_o(avail), .item_o(item)
  );

  mch_back u_back (
    .clk_i, .rst_ni,
    .avail_i(avail), .item_i(item), .pop_o(pop),
    .done_o, .rsp_o
  );

endmodule

// ===== sim/mac_class_hash_table_checker.sv =====
// Checker for the station address class table: tracks accepted requests,
// predicts each response from its own copy of the table, and compares.
// Depends on mch_pkg.
`timescale 1ns / 100ps
module mac_class_hash_table_checker import mch_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        busy,
  input  req_t        req_i,
  input  logic        done_o,
  input  rsp_t        rsp_o,
  output int unsigned fail_count,
  output int unsigned pending_count,
  output int unsigned rsp_count
);

  logic [ID_W-1:0]       head_tbl [BUCKETS];
  logic [KEY_W-1:0]      key_tbl  [ENTRIES];
  logic [CLASS_BITS-1:0] cls_tbl  [ENTRIES];
  logic [ID_W-1:0]       nxt_tbl  [ENTRIES];
  logic [ID_W-1:0]       prv_tbl  [ENTRIES];
  logic [ID_W-1:0]       fnx_tbl  [ENTRIES];
  logic [ID_W-1:0]       fhead;
  rsp_t                  rsp_queue [$];

  function automatic logic [ID_W-1:0] chain_search(logic [BKT_W-1:0] b,
                                                   logic [KEY_W-1:0] k);
    logic [ID_W-1:0] id;
    int steps;
    id = head_tbl[b];
    steps = 0;
    while (id != 0 && steps < ENTRIES) begin
      if (key_tbl[id] == k) return id;
      id = nxt_tbl[id];
      steps++;
    end
    return '0;
  endfunction

  function automatic rsp_t table_apply(req_t r);
    rsp_t o;
    logic [BKT_W-1:0] b;
    logic [ID_W-1:0] id, n, h, p, nx;
    b = r.mac_address[BKT_W-1:0];
    id = chain_search(b, r.mac_address);
    o = '0;
    o.found = (id != 0);
    if (r.cmd == CMD_INSERT) begin
      if (id != 0) begin
        cls_tbl[id] = r.class_value;
        o.status = STATUS_UPDATED;
      end else if (fhead == 0) begin
        o.status = STATUS_FULL;
      end else begin
        n = fhead;
        h = head_tbl[b];
        fhead = fnx_tbl[n];
        fnx_tbl[n] = '0;
        key_tbl[n] = r.mac_address;
        cls_tbl[n] = r.class_value;
        nxt_tbl[n] = h;
        if (h != 0) prv_tbl[h] = n;
        prv_tbl[n] = '0;
        head_tbl[b] = n;
        o.status = STATUS_INSERTED;
      end
    end else if (r.cmd == CMD_REMOVE) begin
      if (id != 0) begin
        p = prv_tbl[id];
        nx = nxt_tbl[id];
        if (p != 0) nxt_tbl[p] = nx;
        else head_tbl[b] = nx;
        if (nx != 0) prv_tbl[nx] = p;
        prv_tbl[id] = '0;
        nxt_tbl[id] = '0;
        fnx_tbl[id] = fhead;
        fhead = id;
        o.status = STATUS_REMOVED;
      end else begin
        o.status = STATUS_ABSENT;
      end
    end else begin
      // Command 3 is treated as a lookup.
      if (id != 0) begin
        o.class_out = cls_tbl[id];
        o.status = STATUS_FOUND;
      end else begin
        o.status = STATUS_ABSENT;
      end
    end
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: response %0d %s mismatch: got %0h expected %0h",
             $realtime, rsp_count, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    rsp_count = 0;
    for (int i = 0; i < BUCKETS; i++) head_tbl[i] = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      nxt_tbl[i] = '0;
      prv_tbl[i] = '0;
      fnx_tbl[i] = (i + 1 < ENTRIES) ? ID_W'(i + 1) : '0;
    end
    fhead = ID_W'(1);
  end

  assign pending_count = rsp_queue.size();

  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni) begin
      // A response seen here belongs to an earlier request, so check it before queueing.
      if (done_o) begin
        if (rsp_queue.size() == 0) begin
          $display("%0t: response with no request outstanding", $realtime);
          fail_count++;
        end else begin
          want = rsp_queue.pop_front();
          if (rsp_o.status !== want.status)
            report_mismatch("status", 32'(rsp_o.status), 32'(want.status));
          if (rsp_o.found !== want.found)
            report_mismatch("found", 32'(rsp_o.found), 32'(want.found));
          if (rsp_o.class_out !== want.class_out)
            report_mismatch("class_out", rsp_o.class_out, want.class_out);
        end
        rsp_count++;
      end
      if (start && !busy) rsp_queue.push_back(table_apply(req_i));
    end
  end

endmodule

// ===== sim/mac_class_hash_table_tb.sv =====
// Testbench top for the station address class table: clock, reset, request
// stimulus and the verdict. Depends on mch_pkg, mac_class_hash_table and the checker.
`timescale 1ns / 100ps
module mac_class_hash_table_tb;
  import mch_pkg::*;

  // Each transaction walks at most ENTRIES chain entries plus fixed overhead, and
  // two can queue, so this idle limit is generous for any correct run.
  localparam int unsigned IDLE_LIMIT = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  req_t        req_i = '0;
  logic        done_o;
  rsp_t        rsp_o;
  int unsigned fail_count, pending_count, rsp_count;
  int unsigned idle_cycles = 0;
  int unsigned sent = 0;
  logic [47:0] key_pool [32];

  always #5 clk_i = ~clk_i;

  mac_class_hash_table dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .req_i(req_i), .done_o(done_o), .rsp_o(rsp_o)
  );

  mac_class_hash_table_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .req_i(req_i), .done_o(done_o), .rsp_o(rsp_o),
    .fail_count(fail_count), .pending_count(pending_count), .rsp_count(rsp_count)
  );

  // Watchdog: counts cycles in which neither a request nor a response moves.
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired after %0d idle cycles", idle_cycles);
      $display("mac_class_hash_table test failed");
      $finish;
    end
  end

  // Drives one request and holds it until the block takes it, after a random gap.
  // Start stays high after the accepting edge so that a zero gap gives
  // back-to-back requests; the gap or a drain drops it.
  task automatic send_request(logic [1:0] c, logic [47:0] k, logic [31:0] v);
    int unsigned gap;
    gap = $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= '{cmd: c, mac_address: k, class_value: v};
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sent++;
  endtask

  task automatic drain_responses();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
  endtask

  function automatic logic [47:0] random_key();
    return {16'($urandom()), $urandom()};
  endfunction

  initial begin
    logic [47:0] k;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: extreme keys and classes, every command, reserved command 3,
    // update of an existing entry, removal from the middle and head of a chain.
    send_request(CMD_INSERT, 48'h0, 32'h0);
    send_request(CMD_INSERT, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    send_request(CMD_LOOKUP, 48'hFFFF_FFFF_FFFF, 32'h0);
    send_request(CMD_RESERVED, 48'h0, 32'h1234);
    send_request(CMD_INSERT, 48'h0, 32'hA5A5_5A5A);
    send_request(CMD_LOOKUP, 48'h0, 32'hFFFF_FFFF);
    send_request(CMD_INSERT, 48'h1_0000_00FF, 32'h1);
    send_request(CMD_INSERT, 48'h2_0000_00FF, 32'h2);
    send_request(CMD_REMOVE, 48'h1_0000_00FF, 32'h0);
    send_request(CMD_LOOKUP, 48'h2_0000_00FF, 32'h0);
    send_request(CMD_LOOKUP, 48'hFFFF_FFFF_FFFF, 32'h0);
    send_request(CMD_REMOVE, 48'h2_0000_00FF, 32'h0);
    send_request(CMD_REMOVE, 48'h2_0000_00FF, 32'h0);
    send_request(CMD_LOOKUP, 48'h5555_5555_5555, 32'h0);
    send_request(CMD_REMOVE, 48'hAAAA_AAAA_AAAA, 32'hFFFF_FFFF);

    // The sender holds off here until every outstanding response has come.
    drain_responses();

    // Random part: mostly operations on a small key pool, so hits, updates and
    // shared buckets are common; the rest fully random keys and commands.
    for (int i = 0; i < 32; i++) begin
      k = random_key();
      if (i < 16) k[7:0] = 8'(i % 3);
      key_pool[i] = k;
    end
    for (int i = 0; i < 385; i++) begin
      if ($urandom_range(0, 9) < 8)
        send_request(2'($urandom_range(0, 3)), key_pool[$urandom_range(0, 31)],
                     $urandom());
      else
        send_request(2'($urandom()), random_key(), $urandom());
      if (i == 200) drain_responses();
    end

    drain_responses();
    repeat (50) @(posedge clk_i);
    $display("Ran %0d requests with %0d responses: directed edges, every command", sent,
             rsp_count);
    $display("and random traffic over shared buckets with updates and removals.");
    if (fail_count == 0 && pending_count == 0) begin
      $display("mac_class_hash_table test passed");
    end else begin
      $display("mac_class_hash_table test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/mch_pkg.sv
sv/mch_front.sv
sv/mch_back.sv
sv/mac_class_hash_table.sv
sim/mac_class_hash_table_checker.sv
sim/mac_class_hash_table_tb.sv
